/* design/spal_pkg.sv */
// Package for the slot pool with active list.
// Holds the word types, codes, widths and link helper functions.
// No dependencies.
`default_nettype none

package spal_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = 6;
    localparam int IMG_W      = 10;
    localparam int LINK_W     = 7;
    localparam int ADDR_W     = $clog2(POOL_SLOTS);
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

    localparam logic [LINK_W-1:0] NIL_CODE = 7'd64;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_LIST    = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req_code;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_NOT_ACTIVE = 2'd2,
        ST_LIST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_WR,
        S_A_FIN,
        S_R_RD,
        S_R_W1,
        S_R_W2,
        S_R_FIN,
        S_L_RD,
        S_L_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IMG_W-1:0]  image_id;
        logic [SLOT_W-1:0] slot_in;
    } t_req_word;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic [IMG_W-1:0]  stored_image;
        logic [1:0]        status;
        logic              last_of_run;
    } t_rsp_word;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } t_link_rd;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } t_link_wr;

    function automatic logic is_slot(input logic [LINK_W-1:0] v);
        return v < LINK_W'(POOL_SLOTS);
    endfunction

    function automatic logic [LINK_W-1:0] or_nil(input logic [LINK_W-1:0] v);
        return is_slot(v) ? v : NIL_CODE;
    endfunction

    function automatic logic [LINK_W-1:0] dflt_next(input logic [SLOT_W-1:0] a);
        logic [LINK_W-1:0] v;
        v = LINK_W'(a) + LINK_W'(1);
        return is_slot(v) ? v : NIL_CODE;
    endfunction

    function automatic logic [LINK_W-1:0] dflt_prev(input logic [SLOT_W-1:0] a);
        return (a != '0) ? (LINK_W'(a) - LINK_W'(1)) : NIL_CODE;
    endfunction

    function automatic t_rsp_word make_rsp(input logic [SLOT_W-1:0] slot,
                                           input logic [IMG_W-1:0]  img,
                                           input t_status           st,
                                           input logic              last);
        t_rsp_word w;
        w.slot_out     = slot;
        w.stored_image = img;
        w.status       = st;
        w.last_of_run  = last;
        return w;
    endfunction

endpackage

`default_nettype wire

/* design/slot_pool_with_active_list.sv */
// Top level of the slot pool allocator with free and active lists.
// Depends on spal_pkg and spal_link_store.
//
// A request word is taken when start is high and busy is low; every result
// word appears on o_rsp for one cycle with o_strobe and cannot be held off.
// Allocate and release pass through their read, write and finish states,
// set by the dependent reads and writes through the single write port of
// each link memory. List gives one word per active slot from S_L_OUT, one
// link memory read per listed slot. Clear, pool empty, slot not active and
// list empty answer in the next cycle without raising busy. Link memories
// need no clearing pass: reset and clear take effect at once.
`default_nettype none

module slot_pool_with_active_list (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  spal_pkg::t_req_word   i_req,
    output logic                  o_strobe,
    output spal_pkg::t_rsp_word   o_rsp
);
    import spal_pkg::*;

    t_state                r_state, n_state;
    logic [LINK_W-1:0]     r_free_head, n_free_head;
    logic [LINK_W-1:0]     r_act_head, n_act_head;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [IMG_W-1:0]      r_img, n_img;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_strobe, n_strobe;
    t_rsp_word             r_rsp, n_rsp;
    logic [POOL_SLOTS-1:0] r_busy_map;
    logic [IMG_W-1:0]      r_img_mem [POOL_SLOTS];
    logic [IMG_W-1:0]      r_img_q;

    t_link_rd              lk_rd;
    t_link_wr              nxt_wr;
    t_link_wr              prv_wr;
    logic                  lk_clr;
    logic [LINK_W-1:0]     lk_next;
    logic [LINK_W-1:0]     lk_prev;
    logic                  img_we;
    logic                  busy_set;
    logic                  busy_clr;
    logic                  last;

    spal_link_store u_links (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (lk_clr),
        .i_rd     (lk_rd),
        .i_nxt_wr (nxt_wr),
        .i_prv_wr (prv_wr),
        .o_next   (lk_next),
        .o_prev   (lk_prev)
    );

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            r_img_mem[r_slot[ADDR_W-1:0]] <= r_img;
        end
        if (lk_rd.en) begin
            r_img_q <= r_img_mem[lk_rd.addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_act_head  <= NIL_CODE;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_act_head  <= n_act_head;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_img  <= n_img;
        r_cnt  <= n_cnt;
        r_rsp  <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || lk_clr) begin
            r_busy_map <= '0;
        end else if (busy_set) begin
            r_busy_map[r_slot[ADDR_W-1:0]] <= 1'b1;
        end else if (busy_clr) begin
            r_busy_map[r_slot[ADDR_W-1:0]] <= 1'b0;
        end
    end

    assign last = !is_slot(lk_next) || (r_cnt == CNT_W'(POOL_SLOTS - 1));

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_act_head  = r_act_head;
        n_slot      = r_slot;
        n_img       = r_img;
        n_cnt       = r_cnt;
        n_strobe    = 1'b0;
        n_rsp       = r_rsp;
        lk_rd       = '0;
        nxt_wr      = '0;
        prv_wr      = '0;
        lk_clr      = 1'b0;
        img_we      = 1'b0;
        busy_set    = 1'b0;
        busy_clr    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (t_req_code'(i_req.req_type))
                        REQ_ALLOC: begin
                            if (is_slot(r_free_head)) begin
                                n_slot  = r_free_head[SLOT_W-1:0];
                                n_img   = i_req.image_id;
                                n_state = S_A_RD;
                            end else begin
                                n_strobe = 1'b1;
                                n_rsp    = make_rsp('0, '0, ST_EMPTY, 1'b1);
                            end
                        end
                        REQ_RELEASE: begin
                            if (is_slot(LINK_W'(i_req.slot_in)) &&
                                r_busy_map[i_req.slot_in[ADDR_W-1:0]]) begin
                                n_slot  = i_req.slot_in;
                                n_state = S_R_RD;
                            end else begin
                                n_strobe = 1'b1;
                                n_rsp    = make_rsp(i_req.slot_in, '0, ST_NOT_ACTIVE, 1'b1);
                            end
                        end
                        REQ_LIST: begin
                            if (is_slot(r_act_head)) begin
                                n_slot  = r_act_head[SLOT_W-1:0];
                                n_cnt   = '0;
                                n_state = S_L_RD;
                            end else begin
                                n_strobe = 1'b1;
                                n_rsp    = make_rsp('0, '0, ST_LIST_EMPTY, 1'b1);
                            end
                        end
                        REQ_CLEAR: begin
                            lk_clr      = 1'b1;
                            n_free_head = '0;
                            n_act_head  = NIL_CODE;
                            n_strobe    = 1'b1;
                            n_rsp       = make_rsp('0, '0, ST_OK, 1'b1);
                        end
                    endcase
                end
            end
            S_A_RD: begin
                lk_rd.en    = 1'b1;
                lk_rd.addr  = r_slot;
                prv_wr.en   = 1'b1;
                prv_wr.addr = r_slot;
                prv_wr.data = NIL_CODE;
                img_we      = 1'b1;
                busy_set    = 1'b1;
                n_state     = S_A_WR;
            end
            S_A_WR: begin
                nxt_wr.en   = 1'b1;
                nxt_wr.addr = r_slot;
                nxt_wr.data = or_nil(r_act_head);
                if (is_slot(lk_next)) begin
                    prv_wr.en   = 1'b1;
                    prv_wr.addr = lk_next[SLOT_W-1:0];
                    prv_wr.data = NIL_CODE;
                end
                n_free_head = or_nil(lk_next);
                n_state     = S_A_FIN;
            end
            S_A_FIN: begin
                if (is_slot(r_act_head)) begin
                    prv_wr.en   = 1'b1;
                    prv_wr.addr = r_act_head[SLOT_W-1:0];
                    prv_wr.data = LINK_W'(r_slot);
                end
                n_act_head = LINK_W'(r_slot);
                n_strobe   = 1'b1;
                n_rsp      = make_rsp(r_slot, r_img, ST_OK, 1'b1);
                n_state    = S_IDLE;
            end
            S_R_RD: begin
                lk_rd.en   = 1'b1;
                lk_rd.addr = r_slot;
                n_state    = S_R_W1;
            end
            S_R_W1: begin
                if (is_slot(lk_prev)) begin
                    nxt_wr.en   = 1'b1;
                    nxt_wr.addr = lk_prev[SLOT_W-1:0];
                    nxt_wr.data = or_nil(lk_next);
                end else begin
                    n_act_head = or_nil(lk_next);
                end
                if (is_slot(lk_next)) begin
                    prv_wr.en   = 1'b1;
                    prv_wr.addr = lk_next[SLOT_W-1:0];
                    prv_wr.data = or_nil(lk_prev);
                end
                n_state = S_R_W2;
            end
            S_R_W2: begin
                prv_wr.en   = 1'b1;
                prv_wr.addr = r_slot;
                prv_wr.data = NIL_CODE;
                nxt_wr.en   = 1'b1;
                nxt_wr.addr = r_slot;
                nxt_wr.data = or_nil(r_free_head);
                n_state     = S_R_FIN;
            end
            S_R_FIN: begin
                if (is_slot(r_free_head)) begin
                    prv_wr.en   = 1'b1;
                    prv_wr.addr = r_free_head[SLOT_W-1:0];
                    prv_wr.data = LINK_W'(r_slot);
                end
                n_free_head = LINK_W'(r_slot);
                busy_clr    = 1'b1;
                n_strobe    = 1'b1;
                n_rsp       = make_rsp(r_slot, '0, ST_OK, 1'b1);
                n_state     = S_IDLE;
            end
            S_L_RD: begin
                lk_rd.en   = 1'b1;
                lk_rd.addr = r_slot;
                n_state    = S_L_OUT;
            end
            S_L_OUT: begin
                n_strobe = 1'b1;
                n_rsp    = make_rsp(r_slot, r_img_q, ST_OK, last);
                if (last) begin
                    n_state = S_IDLE;
                end else begin
                    lk_rd.en   = 1'b1;
                    lk_rd.addr = lk_next[SLOT_W-1:0];
                    n_slot     = lk_next[SLOT_W-1:0];
                    n_cnt      = r_cnt + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

`ifndef NO_ASSERTIONS
    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("request finished without a result word");

    a_heads_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_slot(r_free_head) && is_slot(r_act_head)) |-> (r_free_head != r_act_head))
        else $error("free and active heads point at the same slot");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_rsp.status != ST_OK)) |-> o_rsp.last_of_run)
        else $error("error word not marked last");

    a_list_busy_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_L_OUT) |-> r_busy_map[r_slot[ADDR_W-1:0]])
        else $error("listed slot is not active");
`endif

endmodule

`default_nettype wire

/* design/spal_link_store.sv */
// Next and prev link memories of the slot pool, with registered read data.
// Per-entry valid bits give the rebuilt free chain after reset or clear.
// Depends on spal_pkg.
`default_nettype none

module spal_link_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr,
    input  spal_pkg::t_link_rd       i_rd,
    input  spal_pkg::t_link_wr       i_nxt_wr,
    input  spal_pkg::t_link_wr       i_prv_wr,
    output logic [spal_pkg::LINK_W-1:0] o_next,
    output logic [spal_pkg::LINK_W-1:0] o_prev
);
    import spal_pkg::*;

    logic [LINK_W-1:0]     r_nxt_mem [POOL_SLOTS];
    logic [LINK_W-1:0]     r_prv_mem [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_nxt_vld;
    logic [POOL_SLOTS-1:0] r_prv_vld;
    logic [LINK_W-1:0]     r_nxt_q;
    logic [LINK_W-1:0]     r_prv_q;
    logic                  r_nxt_qv;
    logic                  r_prv_qv;
    logic [SLOT_W-1:0]     r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_nxt_wr.en) begin
            r_nxt_mem[i_nxt_wr.addr[ADDR_W-1:0]] <= i_nxt_wr.data;
        end
        if (i_prv_wr.en) begin
            r_prv_mem[i_prv_wr.addr[ADDR_W-1:0]] <= i_prv_wr.data;
        end
        if (i_rd.en) begin
            r_nxt_q   <= r_nxt_mem[i_rd.addr[ADDR_W-1:0]];
            r_prv_q   <= r_prv_mem[i_rd.addr[ADDR_W-1:0]];
            r_nxt_qv  <= r_nxt_vld[i_rd.addr[ADDR_W-1:0]];
            r_prv_qv  <= r_prv_vld[i_rd.addr[ADDR_W-1:0]];
            r_rd_addr <= i_rd.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_nxt_vld <= '0;
            r_prv_vld <= '0;
        end else begin
            if (i_nxt_wr.en) begin
                r_nxt_vld[i_nxt_wr.addr[ADDR_W-1:0]] <= 1'b1;
            end
            if (i_prv_wr.en) begin
                r_prv_vld[i_prv_wr.addr[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    assign o_next = r_nxt_qv ? r_nxt_q : dflt_next(r_rd_addr);
    assign o_prev = r_prv_qv ? r_prv_q : dflt_prev(r_rd_addr);

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for slot_pool_with_active_list.
// Depends on spal_pkg; tracks both link lists alongside the block and checks
// every result word against its own prediction.
module testbench;
    import spal_pkg::*;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_req_word  i_req   = '0;
    logic       o_strobe;
    t_rsp_word  o_rsp;

    slot_pool_with_active_list uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [LINK_W-1:0] nxt_of [POOL_SLOTS];
    logic [LINK_W-1:0] prv_of [POOL_SLOTS];
    logic [IMG_W-1:0]  img_of [POOL_SLOTS];
    logic              held   [POOL_SLOTS];
    logic [LINK_W-1:0] act_top;
    logic [LINK_W-1:0] free_top;
    t_rsp_word         owed[$];

    int unsigned fails      = 0;
    int unsigned n_words    = 0;
    int unsigned n_req [4]  = '{0, 0, 0, 0};
    int unsigned n_refused  = 0;
    int unsigned n_rejected = 0;

    function automatic bit linked(input logic [LINK_W-1:0] v);
        return v < LINK_W'(POOL_SLOTS);
    endfunction

    function automatic void owe(input logic [SLOT_W-1:0] s, input logic [IMG_W-1:0] img,
                                input t_status st, input logic is_last);
        t_rsp_word w;
        w.slot_out     = s;
        w.stored_image = img;
        w.status       = st;
        w.last_of_run  = is_last;
        owed.push_back(w);
    endfunction

    function automatic void rebuild_lists();
        for (int i = 0; i < POOL_SLOTS; i++) begin
            nxt_of[i] = (i + 1 < POOL_SLOTS) ? LINK_W'(i + 1) : NIL_CODE;
            prv_of[i] = (i > 0) ? LINK_W'(i - 1) : NIL_CODE;
            img_of[i] = '0;
            held[i]   = 1'b0;
        end
        act_top  = NIL_CODE;
        free_top = '0;
    endfunction

    function automatic void advance_pool(input t_req_word w);
        logic [LINK_W-1:0] s, nf, p, n, cur, nx;
        int k;
        n_req[w.req_type]++;
        case (t_req_code'(w.req_type))
            REQ_ALLOC: begin
                if (!linked(free_top)) begin
                    n_refused++;
                    owe('0, '0, ST_EMPTY, 1'b1);
                end else begin
                    s  = free_top;
                    nf = nxt_of[s];
                    if (linked(nf)) begin
                        prv_of[nf] = NIL_CODE;
                        free_top   = nf;
                    end else begin
                        free_top = NIL_CODE;
                    end
                    prv_of[s] = NIL_CODE;
                    if (linked(act_top)) begin
                        nxt_of[s]       = act_top;
                        prv_of[act_top] = s;
                    end else begin
                        nxt_of[s] = NIL_CODE;
                    end
                    act_top   = s;
                    img_of[s] = w.image_id;
                    held[s]   = 1'b1;
                    owe(s[SLOT_W-1:0], w.image_id, ST_OK, 1'b1);
                end
            end
            REQ_RELEASE: begin
                s = LINK_W'(w.slot_in);
                if (!linked(s) || !held[s]) begin
                    n_rejected++;
                    owe(w.slot_in, '0, ST_NOT_ACTIVE, 1'b1);
                end else begin
                    p = prv_of[s];
                    n = nxt_of[s];
                    if (linked(p))
                        nxt_of[p] = linked(n) ? n : NIL_CODE;
                    else
                        act_top = linked(n) ? n : NIL_CODE;
                    if (linked(n))
                        prv_of[n] = linked(p) ? p : NIL_CODE;
                    prv_of[s] = NIL_CODE;
                    if (linked(free_top)) begin
                        nxt_of[s]        = free_top;
                        prv_of[free_top] = s;
                    end else begin
                        nxt_of[s] = NIL_CODE;
                    end
                    free_top = s;
                    held[s]  = 1'b0;
                    owe(w.slot_in, '0, ST_OK, 1'b1);
                end
            end
            REQ_LIST: begin
                cur = act_top;
                k   = 0;
                if (!linked(cur)) begin
                    owe('0, '0, ST_LIST_EMPTY, 1'b1);
                end else begin
                    while (linked(cur) && k < POOL_SLOTS) begin
                        nx = nxt_of[cur];
                        owe(cur[SLOT_W-1:0], img_of[cur], ST_OK,
                            !linked(nx) || (k + 1 >= POOL_SLOTS));
                        k++;
                        cur = nx;
                    end
                end
            end
            default: begin
                rebuild_lists();
                owe('0, '0, ST_OK, 1'b1);
            end
        endcase
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : check_words
        t_rsp_word want;
        if (i_rst_n && o_strobe) begin
            n_words++;
            if (owed.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, o_rsp);
                fails++;
            end else begin
                want = owed.pop_front();
                report_field("slot_out", want.slot_out, o_rsp.slot_out);
                report_field("stored_image", want.stored_image, o_rsp.stored_image);
                report_field("status", want.status, o_rsp.status);
                report_field("last_of_run", want.last_of_run, o_rsp.last_of_run);
            end
        end
    end

    function automatic t_req_word word_of(input t_req_code code, input int img, input int s);
        t_req_word w;
        w.req_type = code;
        w.image_id = IMG_W'(img);
        w.slot_in  = SLOT_W'(s);
        return w;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_active(input logic [SLOT_W-1:0] fallback);
        logic [SLOT_W-1:0] cand[$];
        for (int i = 0; i < POOL_SLOTS; i++)
            if (held[i]) cand.push_back(SLOT_W'(i));
        if (cand.size() == 0) return fallback;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic send_word(input t_req_word w);
        start <= 1'b1;
        i_req <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        advance_pool(w);
    endtask

    task automatic rest(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random(input bit filling);
        t_req_word w;
        int unsigned r;
        r          = $urandom_range(0, 99);
        w.image_id = IMG_W'($urandom);
        w.slot_in  = SLOT_W'($urandom);
        if (r < (filling ? 55 : 20)) begin
            w.req_type = REQ_ALLOC;
        end else if (r < 86) begin
            w.req_type = REQ_RELEASE;
            if ($urandom_range(0, 9) < 8) w.slot_in = pick_active(w.slot_in);
        end else if (r < 97) begin
            w.req_type = REQ_LIST;
        end else begin
            w.req_type = REQ_CLEAR;
        end
        send_word(w);
    endtask

    task automatic test_basic_requests();
        send_word(word_of(REQ_LIST, 0, 0));
        send_word(word_of(REQ_RELEASE, 0, 0));
        send_word(word_of(REQ_RELEASE, 1023, 63));
        send_word(word_of(REQ_ALLOC, 0, 63));
        send_word(word_of(REQ_ALLOC, 1023, 0));
        send_word(word_of(REQ_ALLOC, 'h155, 'h2a));
        send_word(word_of(REQ_ALLOC, 'h2aa, 'h15));
        send_word(word_of(REQ_LIST, 1023, 63));
        send_word(word_of(REQ_RELEASE, 0, 1));
        send_word(word_of(REQ_RELEASE, 0, 3));
        send_word(word_of(REQ_RELEASE, 0, 0));
        send_word(word_of(REQ_RELEASE, 0, 0));
        send_word(word_of(REQ_LIST, 0, 0));
        send_word(word_of(REQ_ALLOC, 77, 0));
        send_word(word_of(REQ_CLEAR, 1023, 63));
        send_word(word_of(REQ_LIST, 0, 0));
        send_word(word_of(REQ_RELEASE, 0, 2));
        drain();
    endtask

    task automatic test_pool_exhaustion();
        repeat (POOL_SLOTS) send_word(word_of(REQ_ALLOC, $urandom_range(0, 1023), 0));
        send_word(word_of(REQ_ALLOC, 5, 0));
        send_word(word_of(REQ_LIST, 0, 0));
        send_word(word_of(REQ_RELEASE, 0, 63));
        send_word(word_of(REQ_RELEASE, 0, 0));
        send_word(word_of(REQ_RELEASE, 0, 31));
        rest(3);
        repeat (3) send_word(word_of(REQ_ALLOC, $urandom_range(0, 1023), 0));
        send_word(word_of(REQ_ALLOC, 9, 0));
        send_word(word_of(REQ_LIST, 0, 0));
        send_word(word_of(REQ_CLEAR, 0, 0));
        drain();
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        bit filling;
        sent    = 0;
        filling = 1'b1;
        while (sent < 68) begin
            burst = $urandom_range(1, 10);
            repeat (burst) begin
                send_random(filling);
                sent++;
                if (sent % 34 == 0) filling = !filling;
                if (sent == 34) drain();
            end
            if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 6));
        end
        drain();
    endtask

    initial begin
        rebuild_lists();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_requests();
        test_pool_exhaustion();
        test_random_traffic();
        $display("run: %0d result words checked, %0d refused allocates, %0d rejected releases",
                 n_words, n_refused, n_rejected);
        $display("run: %0d allocates, %0d releases, %0d lists, %0d clears",
                 n_req[REQ_ALLOC], n_req[REQ_RELEASE], n_req[REQ_LIST], n_req[REQ_CLEAR]);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/spal_pkg.sv
design/spal_link_store.sv
design/slot_pool_with_active_list.sv
test/testbench.sv
